// ----- sv/frp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants of the FASTA record parser
// Holds the result record, the line phase and decode action types, the result
// kind and error codes, and the byte codes that the parser recognizes.
// ----------------------------------------------------------------------------
package frp_pkg;

  // Byte codes.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_HEADER  = 8'h3E;  // '>'

  // Result kinds.
  localparam logic [2:0] KIND_ID_BYTE  = 3'd0;
  localparam logic [2:0] KIND_SEQ_BYTE = 3'd1;
  localparam logic [2:0] KIND_REC_END  = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_EMPTY_SEQ = 2'd0;
  localparam logic [1:0] ERR_EMPTY_ID  = 2'd1;
  localparam logic [1:0] ERR_NO_HEADER = 2'd2;

  // Result queue geometry.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Output field widths.
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned ELINE_W = 24;

  // Where the parser is within the current line.
  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_HDR_SKIP,
    PH_HDR_ID,
    PH_HDR_REST,
    PH_SEQ
  } phase_t;

  // What one input item does.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ERR_EMPTY_ID,
    ACT_ERR_EMPTY_SEQ,
    ACT_ERR_NO_HEADER,
    ACT_EOI_CLOSE,
    ACT_EOI_DONE,
    ACT_NEWLINE,
    ACT_ID_END,
    ACT_HDR_FIRST,
    ACT_HDR_NEXT,
    ACT_HDR_LIMIT,
    ACT_ID_BYTE,
    ACT_SEQ_BYTE
  } action_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         data;
    logic [IDX_W-1:0]   rec_idx;
    logic [1:0]         err_code;
    logic [ELINE_W-1:0] err_line;
    logic               last;
  } result_t;

  function automatic result_t make_result(input logic [2:0] kind,
                                          input logic [7:0] data,
                                          input logic [IDX_W-1:0] rec_idx,
                                          input logic [1:0] err_code,
                                          input logic [ELINE_W-1:0] err_line);
    result_t r;
    r.kind     = kind;
    r.data     = data;
    r.rec_idx  = rec_idx;
    r.err_code = err_code;
    r.err_line = err_line;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

// ----- sv/fasta_record_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_record_parser: streaming FASTA record parser
// Splits a FASTA byte stream into identifier bytes, sequence bytes, record
// ends and a final done or error result.
// ----------------------------------------------------------------------------
// The parser takes one text byte per transfer on the input channel and can
// accept a new byte in every clock cycle while the result queue has room.
// Each byte is registered, decoded combinationally against the current line
// phase and its results (none, one or two) are written into a four-entry
// result queue, so the input side keeps moving while earlier results wait on
// the output side. Throughput is one byte per cycle as long as bytes produce
// at most one result each and the result channel takes them; an item that
// produces two results (end of a record followed by done) hands both out on
// the single result port, one per transfer. A transfer with in_tuser set
// marks the end of input; its data byte is ignored. Headers are lines whose
// first non-whitespace byte is '>', and the first word after it is returned
// as the identifier. After done or an error the parser is halted: further
// input is accepted and dropped until reset. The max_records register
// (address 0) stops the parse once that many records are complete; zero
// means no limit. Write it only while the parser is idle.
// ----------------------------------------------------------------------------
module fasta_record_parser #(
  parameter int unsigned LINE_BITS  = 24,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic [0:0]  in_tuser,   // [0] end_of_input
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] out_byte, [23:8] record_index,
                                  // [25:24] error_code, [49:26] error_line
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_valid_r, in_valid_nxt;
  logic [7:0]       in_byte_r;
  logic             in_eoi_r;
  logic [15:0]      max_records_r;
  logic             fire;
  logic             room;
  logic [1:0]       push_cnt;
  frp_pkg::result_t res0, res1, out_res;

  // The single register is not address-decoded; paddr is ignored.
  assign pready = 1'b1;
  assign prdata = {16'd0, max_records_r} | {30'd0, paddr & 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_records_r <= '0;
    end else if (psel && penable && pwrite) begin
      max_records_r <= pwdata[15:0];
    end
  end

  // The registered item is processed when the queue can hold both of its
  // possible results.
  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || fire;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eoi_r  <= in_tuser[0];
    end
  end

  frp_core #(
    .LINE_BITS  (LINE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .in_byte     (in_byte_r),
    .in_eoi      (in_eoi_r),
    .max_records (max_records_r),
    .push_cnt    (push_cnt),
    .res0        (res0),
    .res1        (res1)
  );

  frp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (fire ? push_cnt : 2'd0),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {6'd0, out_res.err_line, out_res.err_code, out_res.rec_idx,
                      out_res.data};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

// ----- sv/frp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_core: parser state and per-byte decode
// Classifies one registered input item against the line phase, updates the
// parser state and produces up to two results for the result queue.
// ----------------------------------------------------------------------------
module frp_core #(
  parameter int unsigned LINE_BITS  = 24,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [7:0]                 in_byte,
  input  logic                       in_eoi,
  input  logic [15:0]                max_records,
  output logic [1:0]                 push_cnt,
  output frp_pkg::result_t           res0,
  output frp_pkg::result_t           res1
);

  frp_pkg::phase_t       phase_r, phase_nxt;
  logic                  seen_hdr_r, seen_hdr_nxt;
  logic                  has_data_r, has_data_nxt;
  logic                  halted_r, halted_nxt;
  logic [LINE_BITS-1:0]  line_cnt_r, line_cnt_nxt;
  logic [LINE_BITS-1:0]  hdr_line_r, hdr_line_nxt;
  logic [COUNT_BITS-1:0] rec_done_r, rec_done_nxt;

  logic [COUNT_BITS-1:0] rec_inc;
  logic [LINE_BITS-1:0]  line_inc;
  logic [63:0]           rec64, inc64, line64, hdr64;
  logic [15:0]           idx_cur, idx_inc;
  logic [23:0]           eline_cur, eline_hdr;
  logic                  is_ws, limit_hit;
  frp_pkg::action_t      act;

  assign rec_inc  = (&rec_done_r) ? rec_done_r : rec_done_r + COUNT_BITS'(1);
  assign line_inc = (&line_cnt_r) ? line_cnt_r : line_cnt_r + LINE_BITS'(1);

  // Output fields clamp at their own widths.
  assign rec64     = 64'(rec_done_r);
  assign inc64     = 64'(rec_inc);
  assign line64    = 64'(line_cnt_r);
  assign hdr64     = 64'(hdr_line_r);
  assign idx_cur   = (|rec64[63:16]) ? 16'hFFFF : rec64[15:0];
  assign idx_inc   = (|inc64[63:16]) ? 16'hFFFF : inc64[15:0];
  assign eline_cur = (|line64[63:24]) ? 24'hFFFFFF : line64[23:0];
  assign eline_hdr = (|hdr64[63:24]) ? 24'hFFFFFF : hdr64[23:0];

  assign limit_hit = (max_records != 16'd0) && (inc64 >= 64'(max_records));

  always_comb begin
    is_ws = (in_byte == 8'd32) || ((in_byte >= 8'd9) && (in_byte <= 8'd13));
  end

  // Decode of one item into a single action.
  always_comb begin
    act = frp_pkg::ACT_NONE;
    if (halted_r) begin
      act = frp_pkg::ACT_NONE;
    end else if (in_eoi) begin
      if (phase_r == frp_pkg::PH_HDR_SKIP) begin
        act = frp_pkg::ACT_ERR_EMPTY_ID;
      end else if (seen_hdr_r && !has_data_r) begin
        act = frp_pkg::ACT_ERR_EMPTY_SEQ;
      end else if (seen_hdr_r) begin
        act = frp_pkg::ACT_EOI_CLOSE;
      end else begin
        act = frp_pkg::ACT_EOI_DONE;
      end
    end else if (in_byte == frp_pkg::CHAR_NEWLINE) begin
      if (phase_r == frp_pkg::PH_HDR_SKIP) begin
        act = frp_pkg::ACT_ERR_EMPTY_ID;
      end else begin
        act = frp_pkg::ACT_NEWLINE;
      end
    end else if (is_ws) begin
      if (phase_r == frp_pkg::PH_HDR_ID) begin
        act = frp_pkg::ACT_ID_END;
      end
    end else begin
      case (phase_r)
        frp_pkg::PH_LINE_START: begin
          if (in_byte == frp_pkg::CHAR_HEADER) begin
            if (!seen_hdr_r) begin
              act = frp_pkg::ACT_HDR_FIRST;
            end else if (!has_data_r) begin
              act = frp_pkg::ACT_ERR_EMPTY_SEQ;
            end else if (limit_hit) begin
              act = frp_pkg::ACT_HDR_LIMIT;
            end else begin
              act = frp_pkg::ACT_HDR_NEXT;
            end
          end else if (!seen_hdr_r) begin
            act = frp_pkg::ACT_ERR_NO_HEADER;
          end else begin
            act = frp_pkg::ACT_SEQ_BYTE;
          end
        end
        frp_pkg::PH_HDR_SKIP, frp_pkg::PH_HDR_ID: act = frp_pkg::ACT_ID_BYTE;
        frp_pkg::PH_SEQ:                          act = frp_pkg::ACT_SEQ_BYTE;
        default:                                  act = frp_pkg::ACT_NONE;
      endcase
    end
  end

  // Next state.
  always_comb begin
    phase_nxt    = phase_r;
    seen_hdr_nxt = seen_hdr_r;
    has_data_nxt = has_data_r;
    halted_nxt   = halted_r;
    line_cnt_nxt = line_cnt_r;
    hdr_line_nxt = hdr_line_r;
    rec_done_nxt = rec_done_r;
    if (fire) begin
      case (act)
        frp_pkg::ACT_ERR_EMPTY_ID, frp_pkg::ACT_ERR_EMPTY_SEQ,
        frp_pkg::ACT_ERR_NO_HEADER, frp_pkg::ACT_EOI_DONE: begin
          halted_nxt = 1'b1;
        end
        frp_pkg::ACT_EOI_CLOSE: begin
          rec_done_nxt = rec_inc;
          halted_nxt   = 1'b1;
        end
        frp_pkg::ACT_NEWLINE: begin
          line_cnt_nxt = line_inc;
          phase_nxt    = frp_pkg::PH_LINE_START;
        end
        frp_pkg::ACT_ID_END: phase_nxt = frp_pkg::PH_HDR_REST;
        frp_pkg::ACT_HDR_FIRST: begin
          seen_hdr_nxt = 1'b1;
          hdr_line_nxt = line_cnt_r;
          phase_nxt    = frp_pkg::PH_HDR_SKIP;
        end
        frp_pkg::ACT_HDR_NEXT: begin
          rec_done_nxt = rec_inc;
          has_data_nxt = 1'b0;
          hdr_line_nxt = line_cnt_r;
          phase_nxt    = frp_pkg::PH_HDR_SKIP;
        end
        frp_pkg::ACT_HDR_LIMIT: begin
          rec_done_nxt = rec_inc;
          has_data_nxt = 1'b0;
          halted_nxt   = 1'b1;
        end
        frp_pkg::ACT_ID_BYTE: phase_nxt = frp_pkg::PH_HDR_ID;
        frp_pkg::ACT_SEQ_BYTE: begin
          has_data_nxt = 1'b1;
          phase_nxt    = frp_pkg::PH_SEQ;
        end
        default: begin
        end
      endcase
    end
  end

  // Results of the current item.
  always_comb begin
    push_cnt = 2'd0;
    res0 = frp_pkg::make_result(frp_pkg::KIND_DONE, 8'd0, idx_cur, 2'd0, 24'd0);
    res1 = frp_pkg::make_result(frp_pkg::KIND_DONE, 8'd0, idx_inc, 2'd0, 24'd0);
    case (act)
      frp_pkg::ACT_ERR_EMPTY_ID: begin
        push_cnt = 2'd1;
        res0 = frp_pkg::make_result(frp_pkg::KIND_ERROR, 8'd0, idx_cur,
                                    frp_pkg::ERR_EMPTY_ID, eline_cur);
      end
      frp_pkg::ACT_ERR_EMPTY_SEQ: begin
        push_cnt = 2'd1;
        res0 = frp_pkg::make_result(frp_pkg::KIND_ERROR, 8'd0, idx_cur,
                                    frp_pkg::ERR_EMPTY_SEQ, eline_hdr);
      end
      frp_pkg::ACT_ERR_NO_HEADER: begin
        push_cnt = 2'd1;
        res0 = frp_pkg::make_result(frp_pkg::KIND_ERROR, 8'd0, idx_cur,
                                    frp_pkg::ERR_NO_HEADER, eline_cur);
      end
      frp_pkg::ACT_EOI_CLOSE, frp_pkg::ACT_HDR_LIMIT: begin
        push_cnt = 2'd2;
        res0 = frp_pkg::make_result(frp_pkg::KIND_REC_END, 8'd0, idx_cur, 2'd0, 24'd0);
      end
      frp_pkg::ACT_EOI_DONE: push_cnt = 2'd1;
      frp_pkg::ACT_HDR_NEXT: begin
        push_cnt = 2'd1;
        res0 = frp_pkg::make_result(frp_pkg::KIND_REC_END, 8'd0, idx_cur, 2'd0, 24'd0);
      end
      frp_pkg::ACT_ID_BYTE: begin
        push_cnt = 2'd1;
        res0 = frp_pkg::make_result(frp_pkg::KIND_ID_BYTE, in_byte, idx_cur, 2'd0, 24'd0);
      end
      frp_pkg::ACT_SEQ_BYTE: begin
        push_cnt = 2'd1;
        res0 = frp_pkg::make_result(frp_pkg::KIND_SEQ_BYTE, in_byte, idx_cur, 2'd0, 24'd0);
      end
      default: push_cnt = 2'd0;
    endcase
    res0.last = (push_cnt == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= frp_pkg::PH_LINE_START;
      seen_hdr_r <= 1'b0;
      has_data_r <= 1'b0;
      halted_r   <= 1'b0;
      line_cnt_r <= LINE_BITS'(1);
      hdr_line_r <= '0;
      rec_done_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      seen_hdr_r <= seen_hdr_nxt;
      has_data_r <= has_data_nxt;
      halted_r   <= halted_nxt;
      line_cnt_r <= line_cnt_nxt;
      hdr_line_r <= hdr_line_nxt;
      rec_done_r <= rec_done_nxt;
    end
  end

endmodule

// ----- sv/frp_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_outq: result queue
// A four-entry queue that takes up to two results per cycle from the parser
// core and hands them out one per transfer on the result channel.
// ----------------------------------------------------------------------------
module frp_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  frp_pkg::result_t res0,
  input  frp_pkg::result_t res1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output frp_pkg::result_t out_res
);

  frp_pkg::result_t                 mem_r [frp_pkg::QDEPTH];
  logic [frp_pkg::QPTR_W-1:0]       head_r, head_nxt;
  logic [frp_pkg::QPTR_W-1:0]       tail_r, tail_nxt;
  logic [frp_pkg::QPTR_W-1:0]       tail_p1;
  logic [frp_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[head_r];
  assign pop       = out_valid && out_ready;
  // Room for the worst case of two results from one item.
  assign room      = (count_r <= frp_pkg::QCNT_W'(frp_pkg::QDEPTH - 2));
  assign tail_p1   = tail_r + frp_pkg::QPTR_W'(1);

  always_comb begin
    head_nxt  = pop ? head_r + frp_pkg::QPTR_W'(1) : head_r;
    tail_nxt  = tail_r + frp_pkg::QPTR_W'(push_cnt);
    count_nxt = count_r + frp_pkg::QCNT_W'(push_cnt) - frp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[tail_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[tail_p1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
